>>> hw/rtl/mlkbd_pkg.sv
// ============================================================================
// mlkbd_pkg
// Shared types, register indexes and the Morse symbol table for the lamp
// keyer and button decoder.
// ============================================================================
package mlkbd_pkg;

   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CHAR_W    = 8;
   localparam int TBL_SIZE  = 36;
   localparam int TBL_N_W   = 3;
   localparam int TBL_PAT_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_DOT_ON      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_ON     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_PRESS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_GAP  = 3'd5;

   localparam logic [CFG_W-1:0] RST_DOT_ON     = 16'd300;
   localparam logic [CFG_W-1:0] RST_DASH_ON    = 16'd700;
   localparam logic [CFG_W-1:0] RST_GAP        = 16'd300;
   localparam logic [CFG_W-1:0] RST_MIN_PRESS  = 16'd100;
   localparam logic [CFG_W-1:0] RST_DASH_PRESS = 16'd500;
   localparam logic [CFG_W-1:0] RST_LETTER_GAP = 16'd1000;

   localparam logic [CHAR_W-1:0] PLUS_CHAR = 8'h2B;

   typedef struct packed {
      logic [CFG_W-1:0] dot_on_ms;
      logic [CFG_W-1:0] dash_on_ms;
      logic [CFG_W-1:0] gap_ms;
      logic [CFG_W-1:0] min_press_ms;
      logic [CFG_W-1:0] dash_press_ms;
      logic [CFG_W-1:0] letter_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic              lamp_on;
      logic              char_valid;
      logic [CHAR_W-1:0] char_out;
      logic              symbol_error;
   } result_type;

   // element codes: 01 dot, 10 dash, first element in the highest used bits
   typedef struct packed {
      logic [CHAR_W-1:0]    ch;
      logic [TBL_N_W-1:0]   n;
      logic [TBL_PAT_W-1:0] pat;
   } tbl_entry_type;

   typedef struct packed {
      logic                 hit;
      logic [TBL_N_W-1:0]   n;
      logic [TBL_PAT_W-1:0] pat;
   } key_code_type;

   function automatic tbl_entry_type tbl_entry(input logic [5:0] idx);
      tbl_entry_type e;
      case (idx)
         6'd0:  e = '{8'h30, 3'd5, 10'b1010101010};
         6'd1:  e = '{8'h31, 3'd5, 10'b0110101010};
         6'd2:  e = '{8'h32, 3'd5, 10'b0101101010};
         6'd3:  e = '{8'h33, 3'd5, 10'b0101011010};
         6'd4:  e = '{8'h34, 3'd5, 10'b0101010110};
         6'd5:  e = '{8'h35, 3'd5, 10'b0101010101};
         6'd6:  e = '{8'h36, 3'd5, 10'b1001010101};
         6'd7:  e = '{8'h37, 3'd5, 10'b1010010101};
         6'd8:  e = '{8'h38, 3'd5, 10'b1010100101};
         6'd9:  e = '{8'h39, 3'd5, 10'b1010101001};
         6'd10: e = '{8'h41, 3'd2, 10'b0110};
         6'd11: e = '{8'h42, 3'd4, 10'b10010101};
         6'd12: e = '{8'h43, 3'd4, 10'b10011001};
         6'd13: e = '{8'h44, 3'd3, 10'b100101};
         6'd14: e = '{8'h45, 3'd1, 10'b01};
         6'd15: e = '{8'h46, 3'd4, 10'b01011001};
         6'd16: e = '{8'h47, 3'd3, 10'b101001};
         6'd17: e = '{8'h48, 3'd4, 10'b01010101};
         6'd18: e = '{8'h49, 3'd2, 10'b0101};
         6'd19: e = '{8'h4A, 3'd4, 10'b01101010};
         6'd20: e = '{8'h4B, 3'd3, 10'b100110};
         6'd21: e = '{8'h4C, 3'd4, 10'b01100101};
         6'd22: e = '{8'h4D, 3'd2, 10'b1010};
         6'd23: e = '{8'h4E, 3'd2, 10'b1001};
         6'd24: e = '{8'h4F, 3'd3, 10'b101010};
         6'd25: e = '{8'h50, 3'd4, 10'b01101001};
         6'd26: e = '{8'h51, 3'd4, 10'b10100110};
         6'd27: e = '{8'h52, 3'd3, 10'b011001};
         6'd28: e = '{8'h53, 3'd3, 10'b010101};
         6'd29: e = '{8'h54, 3'd1, 10'b10};
         6'd30: e = '{8'h55, 3'd3, 10'b010110};
         6'd31: e = '{8'h56, 3'd4, 10'b01010110};
         6'd32: e = '{8'h57, 3'd3, 10'b011010};
         6'd33: e = '{8'h58, 3'd4, 10'b10010110};
         6'd34: e = '{8'h59, 3'd4, 10'b10011010};
         6'd35: e = '{8'h5A, 3'd4, 10'b10100101};
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic key_code_type char_to_code(input logic [CHAR_W-1:0] ch);
      key_code_type  r;
      tbl_entry_type e;
      r = '0;
      for (int i = 0; i < TBL_SIZE; i++) begin
         e = tbl_entry(6'(i));
         if (e.ch == ch) begin
            r.hit = 1'b1;
            r.n   = e.n;
            r.pat = e.pat;
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/morse_lamp_keyer_and_button_decoder_unit.sv
// ============================================================================
// morse_lamp_keyer_and_button_decoder_unit
// Morse lamp keyer and button decoder, one item per millisecond tick.
// ============================================================================
// A result is registered and appears on rsp_ in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register lets the next item in
// while a result is being taken, and holds the input off only under stall.
// Reset (synchronous): empties the ring, clears keyer and button state, empties the
// result register and loads the register defaults.
module morse_lamp_keyer_and_button_decoder_unit #(
   parameter int BUFFER_DEPTH = 8,
   parameter int MAX_ELEMENTS = 6,
   parameter int TIMER_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // rx_valid, rx_char[7:0], button_down
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // lamp_on, char_valid, char_out[7:0],
                                                         // symbol_error
   input  logic                              csr_we,
   input  logic [mlkbd_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [mlkbd_pkg::CFG_W-1:0]       csr_wdata
);
   import mlkbd_pkg::*;

   cfg_type    cfg_ff;
   result_type res;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       step;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_on_ms     <= RST_DOT_ON;
         cfg_ff.dash_on_ms    <= RST_DASH_ON;
         cfg_ff.gap_ms        <= RST_GAP;
         cfg_ff.min_press_ms  <= RST_MIN_PRESS;
         cfg_ff.dash_press_ms <= RST_DASH_PRESS;
         cfg_ff.letter_gap_ms <= RST_LETTER_GAP;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DOT_ON:     cfg_ff.dot_on_ms     <= csr_wdata;
            CSR_DASH_ON:    cfg_ff.dash_on_ms    <= csr_wdata;
            CSR_GAP:        cfg_ff.gap_ms        <= csr_wdata;
            CSR_MIN_PRESS:  cfg_ff.min_press_ms  <= csr_wdata;
            CSR_DASH_PRESS: cfg_ff.dash_press_ms <= csr_wdata;
            CSR_LETTER_GAP: cfg_ff.letter_gap_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   mlkbd_core #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TIMER_BITS   (TIMER_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_valid    (req_tdata[0]),
      .rx_char     (req_tdata[8:1]),
      .button_down (req_tdata[9]),
      .cfg         (cfg_ff),
      .res         (res)
   );

   always_comb begin
      if (step) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) rsp_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.symbol_error, rsp_ff.char_out,
                        rsp_ff.char_valid, rsp_ff.lamp_on};

endmodule

>>> hw/rtl/mlkbd_core.sv
// ============================================================================
// mlkbd_core
// Character ring, lamp keyer and button timing/decoding; advances one tick
// per accepted item and presents that tick's result combinationally.
// ============================================================================
module mlkbd_core #(
   parameter int BUFFER_DEPTH = 8,
   parameter int MAX_ELEMENTS = 6,
   parameter int TIMER_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   rx_valid,
   input  logic [7:0]             rx_char,
   input  logic                   button_down,
   input  mlkbd_pkg::cfg_type     cfg,
   output mlkbd_pkg::result_type  res
);
   import mlkbd_pkg::*;

   localparam int PW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW   = $clog2(BUFFER_DEPTH + 1);
   localparam int CNTW = $clog2(MAX_ELEMENTS + 2);
   localparam int BPW  = 2 * MAX_ELEMENTS;
   localparam int CW   = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   localparam logic [TIMER_BITS-1:0] TMAX      = '1;
   localparam logic [TIMER_BITS-1:0] TONE      = TIMER_BITS'(1);
   localparam logic [PW-1:0]         PTR_LAST  = PW'(BUFFER_DEPTH - 1);
   localparam logic [FW-1:0]         DEPTH_F   = FW'(BUFFER_DEPTH);
   localparam logic [CNTW-1:0]       CNT_MAX   = CNTW'(MAX_ELEMENTS);
   localparam logic [CNTW-1:0]       CNT_OVER  = CNTW'(MAX_ELEMENTS + 1);

   function automatic logic [TIMER_BITS-1:0] sat(input logic [CFG_W-1:0] v);
      if (CW'(v) > CW'(TMAX)) return TMAX;
      else return TIMER_BITS'(v);
   endfunction

   function automatic logic [TIMER_BITS-1:0] limit(input logic [CFG_W-1:0] v);
      if (v == '0) return TONE;
      else return sat(v);
   endfunction

   function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] t);
      if (t == TMAX) return t;
      else return t + TONE;
   endfunction

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      if (p == PTR_LAST) return '0;
      else return p + PW'(1);
   endfunction

   function automatic logic [7:0] decode(input logic [CNTW-1:0] cnt,
                                         input logic [BPW-1:0] pat);
      logic [7:0]    r;
      tbl_entry_type e;
      r = '0;
      for (int i = 0; i < TBL_SIZE; i++) begin
         e = tbl_entry(6'(i));
         if (cnt == CNTW'(e.n) && pat == BPW'(e.pat)) r = e.ch;
      end
      return r;
   endfunction

   logic [7:0]            ring_ff [BUFFER_DEPTH];
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [TBL_PAT_W-1:0]  key_pat_ff, key_pat_in;
   logic [TBL_N_W-1:0]    key_pos_ff, key_pos_in;
   logic                  key_act_ff, key_act_in;
   logic                  lit_ff, lit_in;
   logic                  gap_ff, gap_in;
   logic                  dash_ff, dash_in;
   logic [TIMER_BITS-1:0] lamp_tmr_ff, lamp_tmr_in;
   logic                  held_ff, held_in;
   logic                  wait_ff, wait_in;
   logic [TIMER_BITS-1:0] btn_tmr_ff, btn_tmr_in;
   logic [BPW-1:0]        btn_pat_ff, btn_pat_in;
   logic [CNTW-1:0]       btn_cnt_ff, btn_cnt_in;

   logic                  wr0_en, wr1_en;
   logic [PW-1:0]         wr0_addr, wr1_addr;
   logic [7:0]            wr1_data;

   always_comb begin
      logic                  rx_push;
      logic [7:0]            popped;
      logic [7:0]            ch;
      logic                  got;
      logic                  err;
      key_code_type          kc;
      logic [TBL_N_W-1:0]    pos_m1;
      logic [1:0]            d;
      logic [TIMER_BITS-1:0] lg_thr;
      logic [TIMER_BITS-1:0] dur;

      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      fill_in     = fill_ff;
      key_pat_in  = key_pat_ff;
      key_pos_in  = key_pos_ff;
      key_act_in  = key_act_ff;
      lit_in      = lit_ff;
      gap_in      = gap_ff;
      dash_in     = dash_ff;
      lamp_tmr_in = lamp_tmr_ff;
      held_in     = held_ff;
      wait_in     = wait_ff;
      btn_tmr_in  = btn_tmr_ff;
      btn_pat_in  = btn_pat_ff;
      btn_cnt_in  = btn_cnt_ff;
      got         = 1'b0;
      err         = 1'b0;
      ch          = '0;
      wr1_en      = 1'b0;
      wr1_addr    = wr_ptr_ff;
      wr1_data    = '0;
      kc          = '0;
      pos_m1      = '0;
      d           = '0;
      dur         = '0;

      // received character
      rx_push  = rx_valid && (rx_char != PLUS_CHAR) && (fill_ff < DEPTH_F);
      wr0_en   = rx_push;
      wr0_addr = wr_ptr_ff;
      if (rx_push) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
         fill_in   = fill_ff + FW'(1);
      end
      popped = (fill_ff == '0) ? rx_char : ring_ff[rd_ptr_ff];

      // lamp timing
      if (lit_ff) begin
         lamp_tmr_in = tick_up(lamp_tmr_ff);
         if (lamp_tmr_in >= limit(dash_ff ? cfg.dash_on_ms : cfg.dot_on_ms)) begin
            lit_in      = 1'b0;
            gap_in      = 1'b1;
            lamp_tmr_in = '0;
         end
      end else if (gap_ff) begin
         lamp_tmr_in = tick_up(lamp_tmr_ff);
         if (lamp_tmr_in >= limit(cfg.gap_ms)) gap_in = 1'b0;
      end
      if (!lit_in && !gap_in) begin
         if (!key_act_in && fill_in != '0) begin
            kc         = char_to_code(popped);
            rd_ptr_in  = ptr_next(rd_ptr_ff);
            fill_in    = fill_in - FW'(1);
            key_act_in = kc.hit;
            if (kc.hit) begin
               key_pat_in = kc.pat;
               key_pos_in = kc.n;
            end
         end
         if (key_act_in && key_pos_in != '0) begin
            pos_m1      = key_pos_in - TBL_N_W'(1);
            d           = key_pat_in[{pos_m1, 1'b0} +: 2];
            key_pos_in  = pos_m1;
            if (pos_m1 == '0) key_act_in = 1'b0;
            dash_in     = (d == 2'b10);
            lit_in      = 1'b1;
            lamp_tmr_in = '0;
         end
      end

      // button: letter gap, then held press, then new press
      lg_thr = sat(cfg.letter_gap_ms);
      if (lg_thr == TMAX) lg_thr = TMAX - TONE;
      if (wait_ff && !button_down) begin
         btn_tmr_in = tick_up(btn_tmr_ff);
         if (btn_tmr_in > lg_thr) begin
            ch = decode(btn_cnt_ff, btn_pat_ff);
            if (ch != '0) begin
               got = 1'b1;
               if (fill_in < DEPTH_F) begin
                  wr1_en    = 1'b1;
                  wr1_addr  = wr_ptr_in;
                  wr1_data  = ch;
                  wr_ptr_in = ptr_next(wr_ptr_in);
                  fill_in   = fill_in + FW'(1);
               end
            end else begin
               err = 1'b1;
            end
            wait_in    = 1'b0;
            btn_pat_in = '0;
            btn_cnt_in = '0;
         end
      end
      if (held_ff) begin
         btn_tmr_in = tick_up(btn_tmr_in);
         if (!button_down) begin
            dur        = btn_tmr_in;
            held_in    = 1'b0;
            wait_in    = 1'b1;
            btn_tmr_in = '0;
            if (dur >= sat(cfg.min_press_ms)) begin
               d = (dur < limit(cfg.dash_press_ms)) ? 2'b01 : 2'b10;
               if (btn_cnt_in < CNT_MAX) begin
                  btn_pat_in = BPW'({btn_pat_in, d});
                  btn_cnt_in = btn_cnt_in + CNTW'(1);
               end else begin
                  btn_cnt_in = CNT_OVER;
               end
            end
         end
      end else if (button_down) begin
         held_in    = 1'b1;
         wait_in    = 1'b0;
         btn_tmr_in = '0;
      end

      res.lamp_on      = lit_in;
      res.char_valid   = got;
      res.char_out     = got ? ch : 8'd0;
      res.symbol_error = err;
   end

   always_ff @(posedge clock) begin
      if (step && wr0_en) ring_ff[wr0_addr] <= rx_char;
      if (step && wr1_en) ring_ff[wr1_addr] <= wr1_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         fill_ff     <= '0;
         key_pat_ff  <= '0;
         key_pos_ff  <= '0;
         key_act_ff  <= 1'b0;
         lit_ff      <= 1'b0;
         gap_ff      <= 1'b0;
         dash_ff     <= 1'b0;
         lamp_tmr_ff <= '0;
         held_ff     <= 1'b0;
         wait_ff     <= 1'b0;
         btn_tmr_ff  <= '0;
         btn_pat_ff  <= '0;
         btn_cnt_ff  <= '0;
      end else if (step) begin
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         fill_ff     <= fill_in;
         key_pat_ff  <= key_pat_in;
         key_pos_ff  <= key_pos_in;
         key_act_ff  <= key_act_in;
         lit_ff      <= lit_in;
         gap_ff      <= gap_in;
         dash_ff     <= dash_in;
         lamp_tmr_ff <= lamp_tmr_in;
         held_ff     <= held_in;
         wait_ff     <= wait_in;
         btn_tmr_ff  <= btn_tmr_in;
         btn_pat_ff  <= btn_pat_in;
         btn_cnt_ff  <= btn_cnt_in;
      end
   end

endmodule

>>> hw/rtl/mlkbd_checker.sv
// ============================================================================
// mlkbd_checker
// Port-level checks on the keyer/decoder, bound to the top level.
// ============================================================================
module mlkbd_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   a_hit_or_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[10]))
      else $error("decoded char and symbol error in one item");

   a_char_zero_when_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[9:2] == 8'd0)
      else $error("char_out nonzero without char_valid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind morse_lamp_keyer_and_button_decoder_unit mlkbd_port_checks u_mlkbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
